/* rtl/blake512_message_padder_top_assert.svh */
// assertion macros for the message padder
`ifndef BLAKE512_MESSAGE_PADDER_TOP_ASSERT_SVH
`define BLAKE512_MESSAGE_PADDER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define B512_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("padder assertion failed");

`define B512_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("padder assertion failed");

`else

`define B512_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define B512_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/b512pad_pkg.sv */
package b512pad_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	localparam logic [3:0] PAD_ONE_WORD  = 4'd13;
	localparam logic [3:0] PAD_ZERO_WORD = 4'd14;
	localparam logic [3:0] PAD_LEN_WORD  = 4'd15;
	localparam logic [3:0] FULL_BYTES    = 4'd8;
	localparam logic [6:0] FULL_BITS     = 7'd64;
	localparam logic [63:0] MARK_BYTE    = 64'h80;

	typedef struct packed {
		logic [63:0] word;
		logic [6:0]  bits;
		logic [3:0]  w;
		logic [4:0]  mark_pos;
		logic [2:0]  mark_byte;
		logic        two_blk;
		logic        fin;
		logic [63:0] blen;
	} cmd_t;

	typedef struct packed {
		logic [63:0] word;
		logic [6:0]  bits;
		logic        bend;
		logic        fblk;
		logic        rend;
	} res_t;

endpackage

/* rtl/b512pad_front.sv */
module b512pad_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                q_full,
	input  logic [63:0]         msg_word,
	input  logic [3:0]          byte_count,
	input  logic                is_final,
	output logic                q_push,
	output b512pad_pkg::cmd_t   q_cmd
);
	import b512pad_pkg::*;

	logic [63:0] blen_q;
	logic [3:0]  wi_q;
	logic [3:0]  n_cl;
	logic        is8;
	logic [6:0]  add_bits;
	logic [63:0] blen_next;
	logic [63:0] keep;
	logic [4:0]  mark_pos;

	assign q_push = push && !q_full;

	always_comb begin
		n_cl = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
		is8 = (n_cl == FULL_BYTES);
		add_bits = is_final ? {n_cl, 3'b000} : FULL_BITS;
		blen_next = blen_q + {57'd0, add_bits};
		keep = ~({64{1'b1}} >> {n_cl, 3'b000});
		mark_pos = {1'b0, wi_q} + {4'd0, is8};

		q_cmd.word = is_final ? (msg_word & keep) : msg_word;
		q_cmd.bits = add_bits;
		q_cmd.w = wi_q;
		q_cmd.mark_pos = mark_pos;
		q_cmd.mark_byte = is8 ? 3'd0 : n_cl[2:0];
		q_cmd.two_blk = (mark_pos > {1'b0, PAD_ONE_WORD});
		q_cmd.fin = is_final;
		q_cmd.blen = blen_next;
	end

	// running length and block position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= '0;
			wi_q <= '0;
		end else if (q_push) begin
			if (is_final) begin
				blen_q <= '0;
				wi_q <= '0;
			end else begin
				blen_q <= blen_next;
				wi_q <= wi_q + 4'd1;
			end
		end
	end

endmodule

/* rtl/b512pad_fifo.sv */
module b512pad_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  b512pad_pkg::cmd_t   wr_cmd,
	input  logic                rd_en,
	output logic                q_full,
	output logic                q_empty,
	output b512pad_pkg::cmd_t   rd_cmd
);
	import b512pad_pkg::*;

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_cmd = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_rd)
				rd_q <= rd_q + QPTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			ent_q[wr_q] <= wr_cmd;
	end

endmodule

/* rtl/b512pad_back.sv */
module b512pad_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  b512pad_pkg::cmd_t   head,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output b512pad_pkg::res_t   res
);
	import b512pad_pkg::*;

	logic [4:0]  j_q;
	logic        active_q;
	logic        valid_q;
	res_t        res_q;
	logic [4:0]  j;
	logic        at_first;
	logic [4:0]  last_j;
	logic        fire;
	logic [63:0] v;
	res_t        nxt;

	assign empty = !valid_q;
	assign res = res_q;
	assign fire = !q_empty && (!valid_q || pop);
	assign q_pop = fire && nxt.rend;

	always_comb begin
		j = active_q ? j_q : {1'b0, head.w};
		at_first = (j == {1'b0, head.w});
		last_j = head.two_blk ? 5'd31 : 5'd15;

		v = at_first ? head.word : '0;
		nxt.fblk = head.fin && (!head.two_blk || j[4]);
		if (head.fin && (j == head.mark_pos))
			v = v | (MARK_BYTE << {3'd7 - head.mark_byte, 3'b000});
		if (nxt.fblk) begin
			unique case (j[3:0])
				PAD_ONE_WORD:  v = v | 64'd1;
				PAD_ZERO_WORD: v = '0;
				PAD_LEN_WORD:  v = head.blen;
				default:       v = v;
			endcase
		end

		nxt.word = v;
		nxt.bits = at_first ? head.bits : 7'd0;
		nxt.bend = (j[3:0] == PAD_LEN_WORD);
		nxt.rend = !head.fin || (j == last_j);
	end

	// word sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			active_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				valid_q <= 1'b1;
				if (nxt.rend) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					j_q <= j + 5'd1;
				end
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= nxt;
	end

endmodule

/* rtl/blake512_message_padder_top.sv */
// Message padder for a 512-bit hash core with 64-bit words. A front stage takes one 64-bit
// message word per cycle while the queue is not full, keeps the running bit length and block
// position, and writes a command into a two-entry queue; a back sequencer turns each command
// into output words at one word per cycle, while the output register is empty or popped, through
// an output register. A non-final word yields one word; a final word yields 3 to 19 words (rest
// of the block, padding, and a second block when the marker falls past word 13), while the front
// keeps taking words until the queue fills. The first word of a transaction passes through the
// queue entry and then the output register before it is on the outputs, where pop takes it.
`include "blake512_message_padder_top_assert.svh"

module blake512_message_padder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] msg_word,
	input  logic [3:0]  byte_count,
	input  logic        is_final,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] out_word,
	output logic [6:0]  message_bits,
	output logic        block_end,
	output logic        final_block,
	output logic        run_end
);
	import b512pad_pkg::*;

	cmd_t wr_cmd;
	cmd_t rd_cmd;
	res_t res;
	logic q_push;
	logic q_full;
	logic q_empty;
	logic q_pop;

	assign full = q_full;

	b512pad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.q_full     (q_full),
		.msg_word   (msg_word),
		.byte_count (byte_count),
		.is_final   (is_final),
		.q_push     (q_push),
		.q_cmd      (wr_cmd)
	);

	b512pad_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_cmd  (wr_cmd),
		.rd_en   (q_pop),
		.q_full  (q_full),
		.q_empty (q_empty),
		.rd_cmd  (rd_cmd)
	);

	b512pad_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (rd_cmd),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign out_word = res.word;
	assign message_bits = res.bits;
	assign block_end = res.bend;
	assign final_block = res.fblk;
	assign run_end = res.rend;

	`B512_ASSERT_SAME(a_bits_range, clk, arst_n, !empty, message_bits <= FULL_BITS)
	`B512_ASSERT_SAME(a_final_ends_block, clk, arst_n, !empty && final_block && run_end, block_end)
	`B512_ASSERT_SAME(a_block_ends_run, clk, arst_n, !empty && final_block && block_end, run_end)
	`B512_ASSERT_SAME(a_plain_full, clk, arst_n, !empty && !final_block && run_end,
		message_bits == FULL_BITS)
	`B512_ASSERT_NEXT(a_queue_holds, clk, arst_n, q_full && !q_pop, q_full)

endmodule
